[hdl/dwd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwd_pkg: shared types and constants for the deque with delete
// Sizes, operation codes, transaction structs and the cell control bundle.
// ----------------------------------------------------------------------------
package dwd_pkg;

  // Number of cells in the row and width of one stored handle.
  localparam int DEPTH      = 16;
  localparam int ITEM_WIDTH = 32;

  // Width of the entry count, which must hold DEPTH itself.
  localparam int COUNT_W = $clog2(DEPTH + 1);

  // Widths fixed by the transaction format.
  localparam int IN_ITEM_W   = 32;
  localparam int OUT_ITEM_W  = 32;
  localparam int OUT_COUNT_W = 5;

  // Operation codes.
  typedef enum logic [1:0] {
    KIND_PREPEND = 2'd0,
    KIND_APPEND  = 2'd1,
    KIND_DEQUEUE = 2'd2,
    KIND_DELETE  = 2'd3
  } kind_e;

  typedef logic [ITEM_WIDTH-1:0] item_t;
  typedef logic [COUNT_W-1:0]    count_t;

  // Input transaction.
  typedef struct packed {
    logic [1:0]           kind;
    logic [IN_ITEM_W-1:0] item_value;
  } dwd_in_t;

  // Result transaction.
  typedef struct packed {
    logic                  status;
    logic [OUT_ITEM_W-1:0] removed_item;
    logic [OUT_COUNT_W-1:0] count_after;
    logic [OUT_ITEM_W-1:0] front_item;
  } dwd_out_t;

  // Contents of one cell as seen by its neighbors.
  typedef struct packed {
    logic  valid;
    item_t val;
  } cell_data_t;

  // Control broadcast to every cell.
  typedef struct packed {
    logic  capture;    // latch the match flag against probe
    item_t probe;      // handle of the incoming transaction
    logic  prepend;    // shift toward the back, new handle at the front
    logic  append;     // first empty cell takes the handle
    logic  dequeue;    // shift toward the front
    logic  delete_en;  // shift toward the front from the first match on
    item_t handle;     // handle of the operation being executed
  } cell_ctrl_t;

endpackage

[hdl/deque_with_delete.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deque_with_delete: bounded double-ended queue of nonzero handles
// A row of shifting cells with the front in cell 0 supports prepend, append,
// dequeue and delete of the frontmost matching handle.
//
//   channel  | handshake           | payload
//   ---------+---------------------+-------------------------------------
//   command  | start, busy         | cmd.kind, cmd.item_value
//   result   | done (one cycle)    | result.status, removed_item,
//            |                     | count_after, front_item
//
// In the accept cycle every cell compares its handle with the incoming one,
// and in the next cycle (busy high) the row shifts along the match chain.
// The result strobes in the cycle after. No transaction is accepted while
// busy is high. Reset clears the count and every valid bit at once, with
// no clearing pass. The receiver cannot stall.
// ----------------------------------------------------------------------------
module deque_with_delete
  import dwd_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  dwd_in_t  cmd,
  output logic     busy,
  output logic     done,
  output dwd_out_t result
);

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

  state_e     state;
  kind_e      op_kind;
  item_t      op_handle;
  count_t     count;
  count_t     count_next;
  logic       accept;
  logic       exec;
  logic       ok;
  logic       can_add;
  cell_ctrl_t ctrl;
  cell_data_t head;
  cell_data_t tail;
  cell_data_t cur [DEPTH];
  cell_data_t nxt [DEPTH];
  logic       found [DEPTH+1];
  logic [DEPTH-1:0] valid_vec;

  assign busy   = (state == ST_EXEC);
  assign accept = start && !busy;
  assign exec   = busy;

  // Success of the operation held in the execute cycle.
  assign can_add = (op_handle != '0) && (count < COUNT_W'(DEPTH));
  always_comb begin
    unique case (op_kind)
      KIND_PREPEND: ok = can_add;
      KIND_APPEND:  ok = can_add;
      KIND_DEQUEUE: ok = (count != '0);
      KIND_DELETE:  ok = (op_handle != '0) && found[DEPTH];
      default:      ok = 1'b0;
    endcase
  end

  // Control broadcast to the cell row.
  always_comb begin
    ctrl.capture   = accept;
    ctrl.probe     = cmd.item_value[ITEM_WIDTH-1:0];
    ctrl.prepend   = exec && (op_kind == KIND_PREPEND) && can_add;
    ctrl.append    = exec && (op_kind == KIND_APPEND) && can_add;
    ctrl.dequeue   = exec && (op_kind == KIND_DEQUEUE) && (count != '0);
    ctrl.delete_en = exec && (op_kind == KIND_DELETE) && (op_handle != '0);
    ctrl.handle    = op_handle;
  end

  // Ends of the row: the new handle enters at the front, emptiness at the back.
  assign head     = '{valid: 1'b1, val: op_handle};
  assign tail     = '{valid: 1'b0, val: '0};
  assign found[0] = 1'b0;

  // Row of cells, each wired to its two neighbors.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    cell_data_t left_in;
    cell_data_t right_in;
    if (i == 0) begin : g_first
      assign left_in = head;
    end else begin : g_mid_l
      assign left_in = cur[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_in = tail;
    end else begin : g_mid_r
      assign right_in = cur[i+1];
    end
    dwd_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .left      (left_in),
      .right     (right_in),
      .found_in  (found[i]),
      .found_out (found[i+1]),
      .data      (cur[i]),
      .data_next (nxt[i])
    );
    assign valid_vec[i] = cur[i].valid;
  end

  // Count after the operation.
  always_comb begin
    count_next = count;
    if (ok) begin
      unique case (op_kind) inside
        KIND_PREPEND, KIND_APPEND: count_next = count + COUNT_W'(1);
        KIND_DEQUEUE, KIND_DELETE: count_next = count - COUNT_W'(1);
        default:                   count_next = count;
      endcase
    end
  end

  // Sequencer, count and result registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          state <= ST_IDLE;
          count <= count_next;
          done  <= 1'b1;
        end
        default: state <= ST_IDLE;
      endcase
      if (exec) begin
        result.status       <= !ok;
        result.removed_item <= (ok && (op_kind == KIND_DEQUEUE)) ?
                               OUT_ITEM_W'(cur[0].val) : '0;
        result.count_after  <= OUT_COUNT_W'(count_next);
        result.front_item   <= nxt[0].valid ? OUT_ITEM_W'(nxt[0].val) : '0;
      end
    end
  end

  // Command payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_kind   <= kind_e'(cmd.kind);
      op_handle <= cmd.item_value[ITEM_WIDTH-1:0];
    end
  end

  // The valid cells always match the entry count.
  a_valid_count: assert property (@(posedge clk) disable iff (rst)
    $countones(valid_vec) == 32'(count))
    else $error("valid cells disagree with entry count");

  // A result follows an execute cycle.
  a_done_after_exec: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == ST_EXEC))
    else $error("result strobe without an execute cycle");

  // The reported count is the stored count.
  a_count_reported: assert property (@(posedge clk) disable iff (rst)
    done |-> (32'(result.count_after) == 32'(count)))
    else $error("reported count differs from stored count");

  // A removed handle is only reported on success.
  a_removed_ok: assert property (@(posedge clk) disable iff (rst)
    (done && (result.removed_item != '0)) |-> !result.status)
    else $error("removed handle reported with an error status");

  // The front cell holds an entry exactly when the count is nonzero.
  a_front_valid: assert property (@(posedge clk) disable iff (rst)
    cur[0].valid == (count != '0))
    else $error("front cell validity disagrees with count");

endmodule

[hdl/dwd_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwd_cell: one storage cell of the deque row
// Holds one handle and its valid bit, and takes its neighbor's contents or
// the new handle when the row shifts.
// ----------------------------------------------------------------------------
module dwd_cell
  import dwd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cell_ctrl_t ctrl,
  input  cell_data_t left,       // neighbor toward the front
  input  cell_data_t right,      // neighbor toward the back
  input  logic       found_in,   // a match lies in front of this cell
  output logic       found_out,  // a match lies here or in front
  output cell_data_t data,
  output cell_data_t data_next
);

  logic  valid;
  item_t val;
  logic  match;
  logic  hit;

  assign data = '{valid: valid, val: val};

  // A match only counts on a cell that holds an entry.
  assign hit       = match & valid;
  assign found_out = found_in | hit;

  // Select what this cell holds after the operation.
  always_comb begin
    data_next = data;
    if (ctrl.prepend) begin
      data_next = left;
    end else if (ctrl.append) begin
      if (!valid && left.valid) begin
        data_next = '{valid: 1'b1, val: ctrl.handle};
      end
    end else if (ctrl.dequeue) begin
      data_next = right;
    end else if (ctrl.delete_en && found_out) begin
      data_next = right;
    end
  end

  // Valid bit is control state and is cleared by reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= data_next.valid;
    end
  end

  // Stored handle and the match flag for a pending delete.
  always_ff @(posedge clk) begin
    val <= data_next.val;
    if (ctrl.capture) begin
      match <= (val == ctrl.probe);
    end
  end

endmodule

[bench/deque_with_delete_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deque_with_delete_test: self-checking bench for the deque with delete
// Drives prepend, append, dequeue and delete commands through the start/busy
// handshake and predicts every result with a queue-based model of the store.
// Each strobed result is checked field by field against the oldest
// prediction. Directed cases cover null handles, empty and full stores,
// duplicates and misses. Random traffic then swings the fill level between
// empty and full under several sender idle rates.
// ----------------------------------------------------------------------------
module deque_with_delete_test;
  import dwd_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int MAX_REPORTED = 10;
  localparam int DRAIN_CYCLES = 10;

  logic     clk;
  logic     rst;
  logic     start;
  dwd_in_t  cmd;
  logic     busy;
  logic     done;
  dwd_out_t result;

  // Model of the stored handles, front at index 0, and the predicted results.
  item_t    stored_handles[$];
  dwd_out_t pending_results[$];

  int mismatch_count;
  int cycle_count;
  int sender_idle_pct;

  deque_with_delete dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done),
    .result (result)
  );

  // Clock with a 12 ns period.
  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // Applies one command to the model and returns the result it must produce.
  function automatic dwd_out_t apply_to_store(kind_e kind, logic [IN_ITEM_W-1:0] raw);
    item_t    handle;
    item_t    taken;
    logic     failed;
    int       hit;
    dwd_out_t res;
    handle = item_t'(raw);
    taken  = '0;
    failed = 1'b0;
    hit    = -1;
    case (kind)
      KIND_PREPEND: begin
        if (handle == '0 || stored_handles.size() >= DEPTH) failed = 1'b1;
        else stored_handles.push_front(handle);
      end
      KIND_APPEND: begin
        if (handle == '0 || stored_handles.size() >= DEPTH) failed = 1'b1;
        else stored_handles.push_back(handle);
      end
      KIND_DEQUEUE: begin
        if (stored_handles.size() == 0) failed = 1'b1;
        else taken = stored_handles.pop_front();
      end
      default: begin
        // Only the frontmost matching handle goes away.
        if (handle != '0) begin
          for (int i = 0; i < stored_handles.size(); i++) begin
            if (hit < 0 && stored_handles[i] == handle) hit = i;
          end
        end
        if (hit < 0) failed = 1'b1;
        else stored_handles.delete(hit);
      end
    endcase
    res.status       = failed;
    res.removed_item = OUT_ITEM_W'(taken);
    res.count_after  = OUT_COUNT_W'(stored_handles.size());
    res.front_item   = (stored_handles.size() > 0) ? OUT_ITEM_W'(stored_handles[0]) : '0;
    return res;
  endfunction

  // Sends one transaction, with random idle cycles ahead of it, and records
  // its predicted result once the block accepts it.
  task automatic send_command(kind_e kind, logic [IN_ITEM_W-1:0] value);
    @(negedge clk);
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start           <= 1'b1;
    cmd.kind        <= kind;
    cmd.item_value  <= value;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_results.push_back(apply_to_store(kind, value));
  endtask

  // Stops sending and waits until every predicted result has arrived.
  task automatic wait_for_results();
    @(negedge clk);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Checks each strobed result against the oldest prediction.
  always @(posedge clk) begin
    dwd_out_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTED)
          $display("%0t: unexpected result: status %0d removed %h count %0d front %h",
                   $time, result.status, result.removed_item, result.count_after,
                   result.front_item);
      end else begin
        want = pending_results.pop_front();
        if (result.status !== want.status || result.removed_item !== want.removed_item ||
            result.count_after !== want.count_after ||
            result.front_item !== want.front_item) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTED) begin
            $display("%0t: result mismatch", $time);
            $display("  status   expected %0d got %0d", want.status, result.status);
            $display("  removed  expected %h got %h", want.removed_item, result.removed_item);
            $display("  count    expected %0d got %0d", want.count_after, result.count_after);
            $display("  front    expected %h got %h", want.front_item, result.front_item);
          end
        end
      end
    end
  end

  // Watchdog on the length of the run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Errors on an empty store and null handles on every operation.
  task automatic test_empty_and_null();
    send_command(KIND_DEQUEUE, 32'h0000_0000);
    send_command(KIND_PREPEND, 32'h0000_0000);
    send_command(KIND_APPEND,  32'h0000_0000);
    send_command(KIND_DELETE,  32'h0000_0000);
  endtask

  // Ordering at both ends, duplicate handles, delete misses and middle deletes.
  task automatic test_order_and_delete();
    send_command(KIND_APPEND,  32'hFFFF_FFFF);
    send_command(KIND_PREPEND, 32'h0000_0001);
    send_command(KIND_APPEND,  32'hAAAA_AAAA);
    send_command(KIND_PREPEND, 32'hAAAA_AAAA);
    send_command(KIND_DELETE,  32'hAAAA_AAAA);
    send_command(KIND_DELETE,  32'h5555_5555);
    send_command(KIND_DELETE,  32'hFFFF_FFFF);
    send_command(KIND_DEQUEUE, 32'h8000_0000);
  endtask

  // Fills the store to capacity and tries one more insert at each end.
  task automatic test_fill_to_capacity();
    while (stored_handles.size() < DEPTH) begin
      if (stored_handles.size() % 2 == 0) send_command(KIND_APPEND, $urandom());
      else send_command(KIND_PREPEND, 32'h8000_0000 | $urandom());
    end
    send_command(KIND_PREPEND, 32'h1234_5678);
    send_command(KIND_APPEND,  32'h8765_4321);
  endtask

  // Random traffic that swings between filling and draining the store.
  task automatic test_random_traffic(int item_total, int idle_pct);
    item_t  pool [8];
    int     roll;
    int     pick;
    bit     filling;
    kind_e  kind;
    logic [IN_ITEM_W-1:0] value;
    sender_idle_pct = idle_pct;
    filling = 1'b1;
    for (int i = 0; i < 8; i++) pool[i] = $urandom();
    pool[0] = 32'hFFFF_FFFF;
    pool[1] = 32'h0000_0001;
    for (int n = 0; n < item_total; n++) begin
      // Change direction now and then, and refresh part of the handle pool.
      if ($urandom_range(29) == 0) filling = !filling;
      if ($urandom_range(9) == 0) pool[$urandom_range(7)] = $urandom();
      roll = $urandom_range(99);
      if (filling) begin
        if (roll < 38) kind = KIND_PREPEND;
        else if (roll < 76) kind = KIND_APPEND;
        else if (roll < 88) kind = KIND_DEQUEUE;
        else kind = KIND_DELETE;
      end else begin
        if (roll < 12) kind = KIND_PREPEND;
        else if (roll < 24) kind = KIND_APPEND;
        else if (roll < 62) kind = KIND_DEQUEUE;
        else kind = KIND_DELETE;
      end
      // Handles: mostly from the pool so duplicates occur, some fully random,
      // a few null; deletes mostly target a handle that is stored.
      pick = $urandom_range(99);
      if (pick < 5) value = '0;
      else if (pick < 30) value = $urandom();
      else value = pool[$urandom_range(7)];
      if (kind == KIND_DELETE && stored_handles.size() > 0 && pick >= 25)
        value = stored_handles[$urandom_range(stored_handles.size() - 1)];
      send_command(kind, value);
    end
  endtask

  // Lets the block run dry before traffic resumes.
  task automatic test_quiet_pause();
    wait_for_results();
  endtask

  initial begin
    rst             = 1'b1;
    start           = 1'b0;
    cmd             = '0;
    mismatch_count  = 0;
    cycle_count     = 0;
    sender_idle_pct = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_empty_and_null();
    test_order_and_delete();
    test_fill_to_capacity();
    test_random_traffic(250, 34);
    test_quiet_pause();
    test_random_traffic(250, 49);
    test_random_traffic(200, 0);

    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
